// File: rtl/srcf_pkg.sv
// Shared types and constants for the stereo rate converter.
// Holds the item structs, opcodes and divider control struct; no dependencies.
`default_nettype none

package srcf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_BITS    = 3;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 3'd3;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PUSH  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    opcode;
    sample_t host_left;
    sample_t host_right;
    sample_t ret_left;
    sample_t ret_right;
  } srcf_in_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
    logic    dec_valid;
    sample_t dec_left;
    sample_t dec_right;
    logic    underrun;
    logic    push_dropped;
  } srcf_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: rtl/srcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the return FIFO store; no dependencies.
`default_nettype none

module srcf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/srcf_sdiv.sv
// Bit-serial signed divider by a small unsigned factor, truncating toward zero.
// One quotient bit per step; depends on srcf_pkg for the sample type.
`default_nettype none

module srcf_sdiv
  import srcf_pkg::*;
#(
  parameter int NW = 27,
  parameter int FB = 3
) (
  input  wire logic                 clk,
  input  wire div_ctl_t             ctl,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [FB-1:0] den,
  output sample_t                   quo
);

  logic          neg_r;
  logic [NW-1:0] mag_r;
  logic [FB-1:0] rem_r;

  logic [NW-1:0] mag_in;
  logic [FB:0]   rem_sh;
  logic          ge;
  logic [FB:0]   rem_new;
  sample_t       q_mag;

  assign mag_in  = num[NW-1] ? (~num + NW'(1)) : num;
  assign rem_sh  = {rem_r, mag_r[NW-1]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_new = ge ? (rem_sh - {1'b0, den}) : rem_sh;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r <= num[NW-1];
      mag_r <= mag_in;
      rem_r <= '0;
    end else if (ctl.step) begin
      mag_r <= {mag_r[NW-2:0], ge};
      rem_r <= rem_new[FB-1:0];
    end
  end

  assign q_mag = mag_r[SAMPLE_BITS-1:0];
  assign quo   = neg_r ? (~q_mag + SAMPLE_BITS'(1)) : q_mag;

endmodule

`default_nettype wire

// File: rtl/stereo_rate_converter_fifo_unit.sv
// Top level of the stereo rate converter: boxcar decimator, linear interpolator
// and return FIFO. Depends on srcf_pkg, srcf_sdiv and srcf_ram.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one item per handshake:
//   a host stereo frame (opcode OP_FRAME) or a return pair push (OP_PUSH).
//   Every item yields exactly one result item on out_valid/out_stall/out_data.
//   A host frame passes from accept through a load state, then through the
//   four bit-serial dividers at one quotient bit per cycle, then into the
//   output register. A push passes from accept to the done state, then into
//   the output register. One item is in work at a time; in_stall is low only
//   while no item is in work.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. If out_stall holds it, the following result waits in the
//   block and in_stall stays high until the output register frees.
//   cfg_wr_en/cfg_wr_data write rate_factor; the user must do so only while
//   the block is idle, which the block itself does not enforce.
//   Synchronous active-low reset clears phase, sums, interpolation state,
//   pointers and rate_factor (to 3). The FIFO store needs no clearing pass.
`default_nettype none

module stereo_rate_converter_fifo_unit
  import srcf_pkg::*;
#(
  parameter int MAX_FACTOR = 6,
  parameter int FIFO_DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srcf_in_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srcf_out_t                out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_BITS-1:0] cfg_wr_data
);

  localparam int FB  = $clog2(MAX_FACTOR + 1);
  localparam int PW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int NW  = SAMPLE_BITS + $clog2(MAX_FACTOR) + 1;
  localparam int PRW = SAMPLE_BITS + FB + 2;
  localparam int AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW  = $clog2(NW + 1);

  localparam logic [FB-1:0] MAX_F = FB'(MAX_FACTOR);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r;
  logic [CW-1:0]       cnt_r;
  logic [CFG_BITS-1:0] rate_factor_r;
  logic [PW-1:0]       phase_r;
  logic signed [NW-1:0] sum_left_r, sum_right_r;
  sample_t             prev_left_r, prev_right_r;
  sample_t             tgt_left_r, tgt_right_r;
  logic [AW-1:0]       wp_r, rp_r;
  logic                op_r, end_r, drop_r, underrun_r;
  logic [FB-1:0]       wa_r, wb_r, f_r;
  logic                out_valid_r;
  srcf_out_t           out_data_r;

  logic                accept_in;
  logic [FB-1:0]       f_eff;
  logic [PW-1:0]       r_eff;
  logic                blk_end;
  logic signed [NW-1:0] acc_left, acc_right;
  logic [AW-1:0]       wp_nxt, rp_nxt;
  logic                fifo_full;
  logic                ram_we;
  logic [2*SAMPLE_BITS-1:0] ram_rdata;
  logic signed [PRW-1:0] pl_a, pl_b, pr_a, pr_b, nl_sum, nr_sum;
  logic signed [NW-1:0] num_il, num_ir;
  div_ctl_t            ctl_dec, ctl_int;
  sample_t             q_il, q_ir, q_dl, q_dr;
  logic                out_free;
  logic                dec_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (rate_factor_r == '0) begin
      f_eff = FB'(1);
    end else if (int'(rate_factor_r) > MAX_FACTOR) begin
      f_eff = MAX_F;
    end else begin
      f_eff = FB'(rate_factor_r);
    end
    if (int'(phase_r) >= int'(f_eff)) begin
      r_eff = PW'(f_eff - FB'(1));
    end else begin
      r_eff = phase_r;
    end
  end

  assign blk_end   = (int'(phase_r) + 1 >= int'(f_eff));
  assign acc_left  = sum_left_r + NW'(in_data.host_left);
  assign acc_right = sum_right_r + NW'(in_data.host_right);

  assign wp_nxt    = (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
  assign rp_nxt    = (rp_r == LAST_ADDR) ? '0 : rp_r + AW'(1);
  assign fifo_full = (wp_nxt == rp_r);
  assign ram_we    = accept_in && (in_data.opcode == OP_PUSH) && !fifo_full;

  srcf_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(FIFO_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata({in_data.ret_left, in_data.ret_right}),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  assign pl_a   = PRW'(prev_left_r) * PRW'($signed({1'b0, wa_r}));
  assign pl_b   = PRW'(tgt_left_r) * PRW'($signed({1'b0, wb_r}));
  assign pr_a   = PRW'(prev_right_r) * PRW'($signed({1'b0, wa_r}));
  assign pr_b   = PRW'(tgt_right_r) * PRW'($signed({1'b0, wb_r}));
  assign nl_sum = pl_a + pl_b;
  assign nr_sum = pr_a + pr_b;
  assign num_il = nl_sum[NW-1:0];
  assign num_ir = nr_sum[NW-1:0];

  assign ctl_dec.load = accept_in && (in_data.opcode == OP_FRAME);
  assign ctl_dec.step = (state_r == S_DIV);
  assign ctl_int.load = (state_r == S_LOAD);
  assign ctl_int.step = (state_r == S_DIV);

  srcf_sdiv #(.NW(NW), .FB(FB)) u_div_dl (
    .clk(clk), .ctl(ctl_dec), .num(acc_left), .den(f_r), .quo(q_dl)
  );
  srcf_sdiv #(.NW(NW), .FB(FB)) u_div_dr (
    .clk(clk), .ctl(ctl_dec), .num(acc_right), .den(f_r), .quo(q_dr)
  );
  srcf_sdiv #(.NW(NW), .FB(FB)) u_div_il (
    .clk(clk), .ctl(ctl_int), .num(num_il), .den(f_r), .quo(q_il)
  );
  srcf_sdiv #(.NW(NW), .FB(FB)) u_div_ir (
    .clk(clk), .ctl(ctl_int), .num(num_ir), .den(f_r), .quo(q_ir)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_factor_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      rate_factor_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      phase_r      <= '0;
      sum_left_r   <= '0;
      sum_right_r  <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      tgt_left_r   <= '0;
      tgt_right_r  <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      op_r         <= OP_FRAME;
      end_r        <= 1'b0;
      drop_r       <= 1'b0;
      underrun_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            op_r       <= in_data.opcode;
            underrun_r <= 1'b0;
            if (in_data.opcode == OP_PUSH) begin
              drop_r  <= fifo_full;
              end_r   <= 1'b0;
              if (!fifo_full) begin
                wp_r <= wp_nxt;
              end
              state_r <= S_DONE;
            end else begin
              drop_r <= 1'b0;
              end_r  <= blk_end;
              f_r    <= f_eff;
              wa_r   <= f_eff - FB'(1) - FB'(r_eff);
              wb_r   <= FB'(r_eff) + FB'(1);
              if (blk_end) begin
                phase_r     <= '0;
                sum_left_r  <= '0;
                sum_right_r <= '0;
              end else begin
                phase_r     <= phase_r + PW'(1);
                sum_left_r  <= acc_left;
                sum_right_r <= acc_right;
              end
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (end_r) begin
            prev_left_r  <= tgt_left_r;
            prev_right_r <= tgt_right_r;
            if (rp_r != wp_r) begin
              tgt_left_r  <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
              tgt_right_r <= ram_rdata[SAMPLE_BITS-1:0];
              rp_r        <= rp_nxt;
            end else begin
              tgt_left_r  <= '0;
              tgt_right_r <= '0;
              underrun_r  <= 1'b1;
            end
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NW - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign dec_ok = (op_r == OP_FRAME) && end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r.out_left     <= (op_r == OP_PUSH) ? '0 : q_il;
      out_data_r.out_right    <= (op_r == OP_PUSH) ? '0 : q_ir;
      out_data_r.dec_valid    <= dec_ok;
      out_data_r.dec_left     <= dec_ok ? q_dl : '0;
      out_data_r.dec_right    <= dec_ok ? q_dr : '0;
      out_data_r.underrun     <= underrun_r;
      out_data_r.push_dropped <= (op_r == OP_PUSH) && drop_r;
    end
  end

  a_dec_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.dec_valid) |-> !out_data_r.push_dropped)
    else $error("result flags both a block average and a dropped push");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_PUSH && !drop_r) |-> (wp_r != rp_r))
    else $error("FIFO reads empty after an accepted push");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (int'(phase_r) < MAX_FACTOR))
    else $error("frame phase beyond maximum factor");

  a_underrun_host: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && underrun_r) |-> (op_r == OP_FRAME && end_r))
    else $error("underrun flagged outside a block end");

endmodule

`default_nettype wire
